// ===== rtl/kbd_pkg.sv =====
// Shared types, constants and table functions of the keyed base-85 decryptor.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package kbd_pkg;

  localparam int unsigned NSym = 85;
  localparam logic [6:0] LastSym = 7'd84;
  localparam logic [7:0] InvalidIdx = 8'hFF;
  localparam logic [7:0] DotChar = 8'h2E;
  localparam logic [31:0] ShuffleKey = 32'h12345678;
  localparam logic [31:0] SeedMix1 = 32'h92D68CA2;
  localparam logic [31:0] SeedMix2 = 32'h475EAD11;
  localparam logic [31:0] SeedMix3 = 32'h6E0323B9;
  localparam logic [31:0] PassMix0 = 32'h55555555;
  localparam logic [31:0] PassMix1 = 32'hAAAAAAAA;
  localparam logic [6:0] SkipMod = 7'd13;
  localparam logic [6:0] DigitMod = 7'd85;
  localparam logic [6:0] PadDigit = 7'd84;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_BADHEAD = 2'd2;
  localparam logic [1:0] ST_MAGIC = 2'd3;

  typedef logic [3:0][31:0] xs_t;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_BADHEAD,
    PH_BODY
  } phase_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_HEAD, OP_SEED, OP_INIT,
    OP_SH_DRAW, OP_SH_RD, OP_SH_WA, OP_SH_WB, OP_MAP_RD, OP_MAP_WR,
    OP_SKIP_DRAW, OP_SKIP_DISCARD, OP_STOP, OP_DIG_DRAW, OP_DIGIT,
    OP_EMIT, OP_PAD_START, OP_PAD, OP_DONE
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_HEADCHK, S_INIT, S_SH_DRAW, S_SH_MOD, S_SH_RD,
    S_SH_WA, S_SH_WB, S_MAP_RD, S_MAP_WR, S_BODY, S_SKIP_MOD, S_BODY2,
    S_DIG_MOD, S_EMIT, S_END_CHK, S_PAD, S_DONE
  } ctrl_state_t;

  typedef struct packed {
    phase_t phase;
    logic   head_full;
    logic   seed_go;
    logic   stopped;
    logic   skip_checked;
    logic   rem_done;
    logic   rem_zero;
    logic   rem_busy;
    logic   is_dot;
    logic   ch_valid;
    logic   last;
    logic   grp_empty;
    logic   grp_one;
    logic   grp_four;
    logic   cnt_end;
    logic   pad_end;
    logic   shi_end;
    logic   pass_end;
    logic   emit_end;
    logic   emit_pad;
    logic   out_full;
  } dp_stat_t;

  function automatic xs_t xs_step(xs_t w);
    logic [31:0] t;
    xs_t n;
    t = w[0] ^ (w[0] << 11);
    n[0] = w[1];
    n[1] = w[2];
    n[2] = w[3];
    n[3] = w[3] ^ (w[3] >> 19) ^ t ^ (t >> 8);
    return n;
  endfunction

  function automatic xs_t xs_seed(logic [31:0] s);
    xs_t n;
    n[0] = s;
    n[1] = s ^ SeedMix1;
    n[2] = s ^ SeedMix2;
    n[3] = s ^ SeedMix3;
    return n;
  endfunction

  // Character code of a position in the master alphabet.
  function automatic logic [6:0] alpha_char(logic [6:0] i);
    logic [6:0] r;
    r = 7'h21;
    if (i < 7'd10) r = i + 7'h30;
    else if (i < 7'd36) r = i - 7'd10 + 7'h41;
    else if (i < 7'd62) r = i - 7'd36 + 7'h61;
    else begin
      case (i - 7'd62)
        7'd0: r = 7'h21;  7'd1: r = 7'h23;  7'd2: r = 7'h24;  7'd3: r = 7'h25;
        7'd4: r = 7'h26;  7'd5: r = 7'h28;  7'd6: r = 7'h29;  7'd7: r = 7'h2A;
        7'd8: r = 7'h2B;  7'd9: r = 7'h2D;  7'd10: r = 7'h3B; 7'd11: r = 7'h3C;
        7'd12: r = 7'h3D; 7'd13: r = 7'h3E; 7'd14: r = 7'h3F; 7'd15: r = 7'h40;
        7'd16: r = 7'h5E; 7'd17: r = 7'h5F; 7'd18: r = 7'h60; 7'd19: r = 7'h7B;
        7'd20: r = 7'h7C; 7'd21: r = 7'h7D; 7'd22: r = 7'h7E;
        default: r = 7'h21;
      endcase
    end
    return r;
  endfunction

  // Position of a character in the master alphabet, or InvalidIdx.
  function automatic logic [7:0] master_index(logic [7:0] c);
    logic [7:0] r;
    r = InvalidIdx;
    if (c inside {[8'h30:8'h39]}) r = c - 8'h30;
    else if (c inside {[8'h41:8'h5A]}) r = c - 8'h41 + 8'd10;
    else if (c inside {[8'h61:8'h7A]}) r = c - 8'h61 + 8'd36;
    else begin
      case (c)
        8'h21: r = 8'd62; 8'h23: r = 8'd63; 8'h24: r = 8'd64; 8'h25: r = 8'd65;
        8'h26: r = 8'd66; 8'h28: r = 8'd67; 8'h29: r = 8'd68; 8'h2A: r = 8'd69;
        8'h2B: r = 8'd70; 8'h2D: r = 8'd71; 8'h3B: r = 8'd72; 8'h3C: r = 8'd73;
        8'h3D: r = 8'd74; 8'h3E: r = 8'd75; 8'h3F: r = 8'd76; 8'h40: r = 8'd77;
        8'h5E: r = 8'd78; 8'h5F: r = 8'd79; 8'h60: r = 8'd80; 8'h7B: r = 8'd81;
        8'h7C: r = 8'd82; 8'h7D: r = 8'd83; 8'h7E: r = 8'd84;
        default: r = InvalidIdx;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] magic_byte(logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0: r = 8'h43;
      2'd1: r = 8'h48;
      2'd2: r = 8'h59;
      default: r = 8'h45;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/kbd_rem.sv =====
// Iterative remainder unit: 32-bit dividend by a 7-bit divisor, 4 bits a cycle.
// Depends on nothing but its ports; instantiated by the datapath.
`default_nettype none
module kbd_rem (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [6:0]  divisor,
  output logic             busy,
  output logic             done,
  output logic [6:0]       rem
);

  logic [31:0] dvd;
  logic [6:0]  dvs;
  logic [2:0]  cnt;
  logic [6:0]  rem_next;

  always_comb begin
    logic [7:0] r;
    r = 8'd0;
    rem_next = rem;
    for (int b = 0; b < 4; b++) begin
      r = {rem_next, dvd[31 - b]};
      if (r >= {1'b0, dvs}) r = r - {1'b0, dvs};
      rem_next = r[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= 7'd0;
      cnt  <= 3'd0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd << 4;
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/kbd_dp.sv =====
// Datapath: keystreams, seed, alphabet and lookup memories, radix-85 group,
// byte unscrambling and the output register. Depends on kbd_pkg and kbd_rem.
`default_nettype none
module kbd_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire kbd_pkg::dp_op_t op,
  input  wire logic [7:0]      in_ch,
  input  wire logic            in_last,
  output kbd_pkg::dp_stat_t    st,
  input  wire logic            out_take,
  output logic                 out_full,
  output logic [7:0]           out_byte,
  output logic                 out_isd,
  output logic                 out_done,
  output logic [1:0]           out_st
);
  import kbd_pkg::*;

  logic [7:0]  ch;
  logic        last;
  phase_t      phase;
  logic [3:0]  hcount;
  logic [31:0] seed;
  xs_t         ms, bs, ss;
  logic [32:0] acc;
  logic [2:0]  gcnt;
  logic        skip_checked;
  logic [3:0]  obc;
  logic        magic_ok;
  logic        stopped;
  logic [6:0]  cnt;
  logic [6:0]  shi;
  logic [1:0]  pass;
  logic [1:0]  k;
  logic        pad;

  logic [6:0] sym [NSym];
  logic [6:0] map [128];
  logic [6:0] rda, rdb, mrd;

  xs_t ms_n, bs_n, ss_n;
  logic        rem_start, rem_busy, rem_done;
  logic [31:0] rem_dvd;
  logic [6:0]  rem_dvs, rem;
  logic [7:0]  hidx;
  logic [6:0]  digit;
  logic [7:0]  dsum;
  logic [7:0]  raw, ubyte;
  logic [15:0] rot2;
  logic        emit_end;
  logic        sym_we;
  logic [6:0]  sym_wa, sym_wd, addr_a;
  logic [1:0]  done_st;

  function automatic logic [32:0] mac85(logic [32:0] a, logic [6:0] d);
    return (a << 6) + (a << 4) + (a << 2) + a + {26'd0, d};
  endfunction

  assign ms_n = xs_step(ms);
  assign bs_n = xs_step(bs);
  assign ss_n = xs_step(ss);
  assign hidx = master_index(ch);

  assign rem_start = (op == OP_SH_DRAW) || (op == OP_SKIP_DRAW) || (op == OP_DIG_DRAW);
  assign rem_dvd = (op == OP_SH_DRAW) ? ss_n[3] : ms_n[3];
  assign rem_dvs = (op == OP_SH_DRAW) ? (shi + 7'd1) :
                   (op == OP_SKIP_DRAW) ? SkipMod : DigitMod;

  kbd_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rem_dvd),
    .divisor  (rem_dvs),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem      (rem)
  );

  assign dsum  = {1'b0, mrd} + {1'b0, DigitMod} - {1'b0, rem};
  assign digit = (mrd >= rem) ? (mrd - rem) : dsum[6:0];

  always_comb begin
    case (k)
      2'd0: raw = acc[31:24];
      2'd1: raw = acc[23:16];
      2'd2: raw = acc[15:8];
      default: raw = acc[7:0];
    endcase
  end

  // Rotate right by bits 10:8 of the draw, then XOR with its low byte.
  assign rot2  = {raw, raw} >> bs_n[3][10:8];
  assign ubyte = rot2[7:0] ^ bs_n[3][7:0];
  assign emit_end = pad ? (k == (gcnt[1:0] - 2'd2)) : (k == 2'd3);

  always_comb begin
    if (hcount < 4'd8) done_st = ST_SHORT;
    else if (phase == PH_BADHEAD) done_st = ST_BADHEAD;
    else if (obc < 4'd12 || !magic_ok) done_st = ST_MAGIC;
    else done_st = ST_OK;
  end

  // Alphabet memory: one write port, two registered read ports.
  always_comb begin
    sym_we = 1'b0;
    sym_wa = cnt;
    sym_wd = alpha_char(cnt);
    case (op)
      OP_INIT:  sym_we = 1'b1;
      OP_SH_WA: begin
        sym_we = 1'b1;
        sym_wa = shi;
        sym_wd = rdb;
      end
      OP_SH_WB: begin
        sym_we = 1'b1;
        sym_wa = rem;
        sym_wd = rda;
      end
      default: sym_we = 1'b0;
    endcase
  end

  assign addr_a = (op == OP_SH_RD) ? shi : cnt;

  always_ff @(posedge clk) begin
    if (sym_we) sym[sym_wa] <= sym_wd;
    if (op == OP_SH_RD || op == OP_MAP_RD) begin
      rda <= sym[addr_a];
      rdb <= sym[rem];
    end
  end

  // Only alphabet characters use the lookup result, and all of them are written.
  always_ff @(posedge clk) begin
    if (op == OP_MAP_WR) map[rda] <= cnt;
    mrd <= map[ch[6:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEAD;
      hcount       <= 4'd0;
      seed         <= 32'd0;
      ms           <= '0;
      bs           <= '0;
      acc          <= 33'd0;
      gcnt         <= 3'd0;
      skip_checked <= 1'b0;
      obc          <= 4'd0;
      magic_ok     <= 1'b0;
      stopped      <= 1'b0;
      out_full     <= 1'b0;
    end else begin
      if (out_take) out_full <= 1'b0;
      case (op)
        OP_LATCH: begin
          ch   <= in_ch;
          last <= in_last;
        end
        OP_HEAD: begin
          if (hidx == InvalidIdx) phase <= PH_BADHEAD;
          else if (phase == PH_HEAD) seed[hcount[2:0] * 4 +: 4] <= hidx[3:0];
          hcount <= hcount + 4'd1;
        end
        OP_SEED: begin
          ms       <= xs_seed(seed);
          bs       <= xs_seed(seed);
          ss       <= xs_seed(seed ^ ShuffleKey);
          magic_ok <= 1'b1;
          phase    <= PH_BODY;
          cnt      <= 7'd0;
        end
        OP_INIT: begin
          cnt  <= cnt + 7'd1;
          shi  <= LastSym;
          pass <= 2'd0;
        end
        OP_SH_DRAW: ss <= ss_n;
        OP_SH_WB: begin
          if (shi == 7'd1) begin
            ss[0] <= ss[0] ^ PassMix0;
            ss[1] <= ss[1] ^ PassMix1;
            shi   <= LastSym;
            pass  <= pass + 2'd1;
            cnt   <= 7'd0;
          end else begin
            shi <= shi - 7'd1;
          end
        end
        OP_MAP_WR: cnt <= cnt + 7'd1;
        OP_SKIP_DRAW: ms <= ms_n;
        OP_SKIP_DISCARD: begin
          ms           <= ms_n;
          skip_checked <= 1'b1;
        end
        OP_STOP: begin
          skip_checked <= 1'b0;
          stopped      <= 1'b1;
        end
        OP_DIG_DRAW: begin
          ms           <= ms_n;
          skip_checked <= 1'b0;
        end
        OP_DIGIT: begin
          k   <= 2'd0;
          pad <= 1'b0;
          if (hidx != InvalidIdx) begin
            acc  <= mac85(acc, digit);
            gcnt <= gcnt + 3'd1;
          end
        end
        OP_PAD_START: cnt <= {4'd0, gcnt};
        OP_PAD: begin
          acc <= mac85(acc, PadDigit);
          cnt <= cnt + 7'd1;
          k   <= 2'd0;
          pad <= 1'b1;
        end
        OP_EMIT: begin
          bs <= bs_n;
          k  <= k + 2'd1;
          if (obc < 4'd4 && ubyte != magic_byte(obc[1:0])) magic_ok <= 1'b0;
          if (obc < 4'd12) begin
            obc <= obc + 4'd1;
          end else if (magic_ok) begin
            out_full <= 1'b1;
            out_byte <= ubyte;
            out_isd  <= 1'b1;
            out_done <= 1'b0;
            out_st   <= ST_OK;
          end
          if (emit_end && !pad) begin
            acc  <= 33'd0;
            gcnt <= 3'd0;
          end
        end
        OP_DONE: begin
          out_full     <= 1'b1;
          out_byte     <= 8'd0;
          out_isd      <= 1'b0;
          out_done     <= 1'b1;
          out_st       <= done_st;
          phase        <= PH_HEAD;
          hcount       <= 4'd0;
          seed         <= 32'd0;
          ms           <= '0;
          bs           <= '0;
          acc          <= 33'd0;
          gcnt         <= 3'd0;
          skip_checked <= 1'b0;
          obc          <= 4'd0;
          magic_ok     <= 1'b0;
          stopped      <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    st.phase        = phase;
    st.head_full    = (hcount == 4'd8);
    st.seed_go      = (hcount == 4'd8) && (phase == PH_HEAD);
    st.stopped      = stopped;
    st.skip_checked = skip_checked;
    st.rem_done     = rem_done;
    st.rem_zero     = (rem == 7'd0);
    st.rem_busy     = rem_busy;
    st.is_dot       = (ch == DotChar);
    st.ch_valid     = (hidx != InvalidIdx);
    st.last         = last;
    st.grp_empty    = (gcnt == 3'd0);
    st.grp_one      = (gcnt == 3'd1);
    st.grp_four     = (gcnt == 3'd4);
    st.cnt_end      = (cnt == LastSym);
    st.pad_end      = (cnt == 7'd4);
    st.shi_end      = (shi == 7'd1);
    st.pass_end     = (pass == 2'd2);
    st.emit_end     = emit_end;
    st.emit_pad     = pad;
    st.out_full     = out_full;
  end

endmodule
`default_nettype wire

// ===== rtl/kbd_ctrl.sv =====
// Controller state machine: sequences header, alphabet build, body digits,
// byte emission and the closing item. Depends on kbd_pkg.
`default_nettype none
module kbd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire kbd_pkg::dp_stat_t st,
  output kbd_pkg::dp_op_t        op
);
  import kbd_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (st.phase != PH_BODY) state_next = st.head_full ? S_END_CHK : S_HEADCHK;
        else state_next = st.stopped ? S_END_CHK : S_BODY;
      end
      S_HEADCHK:  state_next = st.seed_go ? S_INIT : S_END_CHK;
      S_INIT:     if (st.cnt_end) state_next = S_SH_DRAW;
      S_SH_DRAW:  state_next = S_SH_MOD;
      S_SH_MOD:   if (st.rem_done) state_next = S_SH_RD;
      S_SH_RD:    state_next = S_SH_WA;
      S_SH_WA:    state_next = S_SH_WB;
      S_SH_WB:    state_next = (st.shi_end && st.pass_end) ? S_MAP_RD : S_SH_DRAW;
      S_MAP_RD:   state_next = S_MAP_WR;
      S_MAP_WR:   state_next = st.cnt_end ? S_END_CHK : S_MAP_RD;
      S_BODY:     state_next = st.skip_checked ? S_BODY2 : S_SKIP_MOD;
      S_SKIP_MOD: if (st.rem_done) state_next = st.rem_zero ? S_END_CHK : S_BODY2;
      S_BODY2:    state_next = st.is_dot ? S_END_CHK : S_DIG_MOD;
      S_DIG_MOD:  begin
        if (st.rem_done) state_next = (st.ch_valid && st.grp_four) ? S_EMIT : S_END_CHK;
      end
      S_EMIT:     begin
        if (!st.out_full && st.emit_end) state_next = st.emit_pad ? S_DONE : S_END_CHK;
      end
      S_END_CHK:  begin
        if (!st.last) state_next = S_IDLE;
        else if (st.phase == PH_BODY && !st.grp_empty) state_next = S_PAD;
        else state_next = S_DONE;
      end
      S_PAD:      if (st.pad_end) state_next = st.grp_one ? S_DONE : S_EMIT;
      S_DONE:     if (!st.out_full) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LATCH;
      end
      S_DISPATCH: if (st.phase != PH_BODY && !st.head_full) op = OP_HEAD;
      S_HEADCHK:  if (st.seed_go) op = OP_SEED;
      S_INIT:     op = OP_INIT;
      S_SH_DRAW:  op = OP_SH_DRAW;
      S_SH_RD:    op = OP_SH_RD;
      S_SH_WA:    op = OP_SH_WA;
      S_SH_WB:    op = OP_SH_WB;
      S_MAP_RD:   op = OP_MAP_RD;
      S_MAP_WR:   op = OP_MAP_WR;
      S_BODY:     if (!st.skip_checked) op = OP_SKIP_DRAW;
      S_SKIP_MOD: if (st.rem_done && st.rem_zero) op = OP_SKIP_DISCARD;
      S_BODY2:    op = st.is_dot ? OP_STOP : OP_DIG_DRAW;
      S_DIG_MOD:  if (st.rem_done) op = OP_DIGIT;
      S_EMIT:     if (!st.out_full) op = OP_EMIT;
      S_END_CHK:  if (st.last && st.phase == PH_BODY && !st.grp_empty) op = OP_PAD_START;
      S_PAD:      op = OP_PAD;
      S_DONE:     if (!st.out_full) op = OP_DONE;
      default:    op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/keyed_base85_stream_decrypt.sv =====
// Keyed base-85 stream decryptor, one text character per input item. After the
// eighth header character the block is busy building its alphabet: it loads 85
// characters into the alphabet memory, makes 252 swaps (each with one keystream
// draw, a remainder in the shared 4-bit-per-cycle divider, two reads and two
// writes) and builds the inverse lookup for the 85 characters. A body character
// makes up to two passes through the divider; a character that completes a
// group unscrambles 4 bytes, and a byte waits while the output register is full.
// The closing item follows last after up to 4 padding digits and the remaining
// bytes. Depends on kbd_pkg, kbd_ctrl, kbd_dp and kbd_rem.
`default_nettype none
module keyed_base85_stream_decrypt (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // ch
  input  wire logic       s_tlast,   // last
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // data_byte
  output logic            m_tlast,   // done_res
  output logic [2:0]      m_tuser    // [0] is_data, [2:1] status
);
  import kbd_pkg::*;

  dp_op_t   op;
  dp_stat_t st;
  logic     out_isd;
  logic [1:0] out_st;

  kbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .op       (op)
  );

  kbd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .in_ch    (s_tdata),
    .in_last  (s_tlast),
    .st       (st),
    .out_take (m_tvalid && m_tready),
    .out_full (m_tvalid),
    .out_byte (m_tdata),
    .out_isd  (out_isd),
    .out_done (m_tlast),
    .out_st   (out_st)
  );

  assign m_tuser = {out_st, out_isd};

`ifndef SYNTH
  // The closing item never carries payload.
  a_done_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser[0])
    else $error("closing item flagged as data");

  // Payload items report a clean status.
  a_data_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ST_OK && !m_tlast)
    else $error("data item with status");

  // A new character is only taken once the divider is quiet.
  a_ready_rem_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !st.rem_busy)
    else $error("input ready while divider busy");
`endif

endmodule
`default_nettype wire
